FILE: hdl/c8ic_pkg.sv
// Package: shared types and constants for the CHIP-8 instruction core.
`timescale 1ns / 1ps
package c8ic_pkg;
    localparam int RAM_BYTES_DEF   = 4096;
    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [2:0] KIND_LOAD  = 3'd0;
    localparam logic [2:0] KIND_READ  = 3'd1;
    localparam logic [2:0] KIND_STEP  = 3'd2;
    localparam logic [2:0] KIND_TICK  = 3'd3;
    localparam logic [2:0] KIND_WRREG = 3'd4;

    localparam logic [2:0] EV_DONE    = 3'd0;
    localparam logic [2:0] EV_CLEAR   = 3'd1;
    localparam logic [2:0] EV_DRAW    = 3'd2;
    localparam logic [2:0] EV_KEYDOWN = 3'd3;
    localparam logic [2:0] EV_KEYUP   = 3'd4;
    localparam logic [2:0] EV_WAIT    = 3'd5;
    localparam logic [2:0] EV_ILLEGAL = 3'd6;
    localparam logic [2:0] EV_READ    = 3'd7;

    localparam logic [11:0] PC_RESET = 12'd512;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_RD    = 10'b0000000010,
        ST_FHI   = 10'b0000000100,
        ST_FLO   = 10'b0000001000,
        ST_EXEC  = 10'b0000010000,
        ST_BCD   = 10'b0000100000,
        ST_STORE = 10'b0001000000,
        ST_LOAD  = 10'b0010000000,
        ST_LDW   = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;
endpackage

FILE: hdl/chip8_instruction_core_top.sv
// CHIP-8 instruction core: one item in, one result beat out.
// Usage:
//  s_axis carries one item per beat; m_axis returns exactly one result beat
//  per item. Items: load RAM byte, read RAM byte, step one instruction,
//  timer tick, write register.
//  RAM (RAM_BYTES) and the call stack are synchronous memories with a
//  registered read; the sixteen V registers sit in a small register file.
//  Load, tick and register write go straight to the output state; a read
//  passes ST_RD; a step passes ST_FHI, ST_FLO and ST_EXEC, then ST_LDW for
//  a return, ST_BCD per digit, ST_STORE per register for FX55 and
//  ST_LOAD then ST_LDW per register for FX65.
//  One item is in work at a time; the next item is taken only after the
//  result of the last one has been handed off.
//  s_axis_tready is high only in the idle state; the result stays in the
//  output register until m_axis_tready takes it, and the next item is
//  accepted in the cycle after that.
//  Reset: PC 512, I, SP, timers and V registers zero; RAM and stack are
//  undefined until written. Display, keypad and random bytes are external:
//  clear, draw and key events go out, answers come back as register writes.
`timescale 1ns / 1ps
module chip8_instruction_core_top
    import c8ic_pkg::*;
#(
    parameter int RAM_BYTES   = RAM_BYTES_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // kind[2:0], address[14:3], data[22:15], reg_index[26:23], random_byte[34:27]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // event_res[2:0], pc_now[14:3], index_addr[26:15], draw_x[34:27],
    // draw_y[42:35], rows[46:43], dest_reg[50:47], read_data[58:51], sound_on[59]
    output logic [63:0] m_axis_tdata
);
    localparam int AW = $clog2(RAM_BYTES);
    localparam int SW = $clog2(STACK_DEPTH);

    logic [7:0]  ram [RAM_BYTES];
    logic [11:0] stk [STACK_DEPTH];
    logic [7:0]  vregs_reg [16];

    state_t      state_reg;
    logic [11:0] addr_reg;
    logic [7:0]  data_reg, rnd_reg;
    logic [11:0] pc_reg, idx_reg;
    logic [SW:0] sp_reg;
    logic [7:0]  dt_reg, st_reg;
    logic [7:0]  ophi_reg, oplo_reg;
    logic [4:0]  cnt_reg;
    logic [1:0]  bcd_reg;
    logic [2:0]  ev_reg;
    logic [7:0]  ox_reg, oy_reg, ord_reg;
    logic [3:0]  orows_reg, odest_reg;
    logic        out_valid_reg;

    // memory ports
    logic          ram_we;
    logic [11:0]   ram_wa, ram_ra;
    logic [7:0]    ram_wd, ram_q;
    logic          stk_we;
    logic [11:0]   stk_wd, stk_q;

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ram[ram_wa[AW-1:0]] <= ram_wd;
        end
        ram_q <= ram[ram_ra[AW-1:0]];
    end

    logic [SW-1:0] stk_wa, stk_ra;
    assign stk_wa = sp_reg[SW-1:0];
    assign stk_ra = sp_reg[SW-1:0] - 1'b1;
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk[stk_wa] <= stk_wd;
        end
        stk_q <= stk[stk_ra];
    end

    // decode
    logic [3:0] op_hi, x, y, n;
    logic [7:0] nn, vx, vy, bcd_digit;
    logic [11:0] nnn;
    assign op_hi = ophi_reg[7:4];
    assign x     = ophi_reg[3:0];
    assign y     = oplo_reg[7:4];
    assign n     = oplo_reg[3:0];
    assign nn    = oplo_reg;
    assign nnn   = {x, oplo_reg};
    assign vx    = vregs_reg[x];
    assign vy    = vregs_reg[y];

    logic [3:0] hund, tens, ones;
    logic [7:0] rem1;
    always_comb
    begin
        hund = (vx >= 8'd200) ? 4'd2 : (vx >= 8'd100) ? 4'd1 : 4'd0;
        rem1 = vx - 8'(hund * 7'd100);
        tens = 4'((16'(rem1) * 16'd205) >> 11);
        ones = 4'(rem1 - 8'(tens * 4'd10));
        case (bcd_reg)
            2'd0:    bcd_digit = {4'd0, hund};
            2'd1:    bcd_digit = {4'd0, tens};
            default: bcd_digit = {4'd0, ones};
        endcase
    end

    logic [8:0] sum9;
    assign sum9 = {1'b0, vx} + {1'b0, vy};

    assign s_axis_tready = (state_reg == ST_IDLE);
    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        ram_ra = pc_reg;
        ram_we = 1'b0;
        ram_wa = addr_reg;
        ram_wd = data_reg;
        stk_we = 1'b0;
        stk_wd = pc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                // a step fetches the high opcode byte at PC
                ram_ra = (s_axis_tdata[2:0] == KIND_STEP) ? pc_reg : s_axis_tdata[14:3];
                ram_we = accept && (s_axis_tdata[2:0] == KIND_LOAD);
                ram_wa = s_axis_tdata[14:3];
                ram_wd = s_axis_tdata[22:15];
            end
            ST_FHI:  ram_ra = pc_reg + 12'd1;
            ST_EXEC:
            begin
                stk_we = (op_hi == 4'h2) && (sp_reg < (SW+1)'(STACK_DEPTH));
            end
            ST_BCD:
            begin
                ram_we = 1'b1;
                ram_wa = idx_reg + 12'(bcd_reg);
                ram_wd = bcd_digit;
            end
            ST_STORE:
            begin
                ram_we = 1'b1;
                ram_wa = idx_reg + 12'(cnt_reg);
                ram_wd = vregs_reg[cnt_reg[3:0]];
            end
            ST_LOAD: ram_ra = idx_reg + 12'(cnt_reg);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= PC_RESET;
            idx_reg       <= '0;
            sp_reg        <= '0;
            dt_reg        <= '0;
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 16; i++)
            begin
                vregs_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        addr_reg  <= s_axis_tdata[14:3];
                        data_reg  <= s_axis_tdata[22:15];
                        rnd_reg   <= s_axis_tdata[34:27];
                        ev_reg    <= EV_DONE;
                        ox_reg    <= '0;
                        oy_reg    <= '0;
                        ord_reg   <= '0;
                        orows_reg <= '0;
                        odest_reg <= '0;
                        state_reg <= ST_OUT;
                        case (s_axis_tdata[2:0])
                            KIND_READ: state_reg <= ST_RD;
                            KIND_STEP: state_reg <= ST_FHI;
                            KIND_TICK:
                            begin
                                if (dt_reg != 8'd0) dt_reg <= dt_reg - 8'd1;
                                if (st_reg != 8'd0) st_reg <= st_reg - 8'd1;
                            end
                            KIND_WRREG: vregs_reg[s_axis_tdata[26:23]] <= s_axis_tdata[22:15];
                            default: ;
                        endcase
                    end
                end
                ST_RD:
                begin
                    ord_reg   <= ram_q;
                    ev_reg    <= EV_READ;
                    state_reg <= ST_OUT;
                end
                ST_FHI:
                begin
                    ophi_reg  <= ram_q;
                    state_reg <= ST_FLO;
                end
                ST_FLO:
                begin
                    oplo_reg  <= ram_q;
                    pc_reg    <= pc_reg + 12'd2;
                    state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    state_reg <= ST_OUT;
                    case (op_hi)
                        4'h0:
                        begin
                            if (nnn == 12'h0E0) ev_reg <= EV_CLEAR;
                            else if (nnn == 12'h0EE)
                            begin
                                if (sp_reg == '0) ev_reg <= EV_ILLEGAL;
                                else
                                begin
                                    sp_reg    <= sp_reg - 1'b1;
                                    state_reg <= ST_LDW;
                                    cnt_reg   <= 5'd31;
                                end
                            end
                        end
                        4'h1: pc_reg <= nnn;
                        4'h2:
                        begin
                            if (sp_reg < (SW+1)'(STACK_DEPTH))
                            begin
                                sp_reg <= sp_reg + 1'b1;
                                pc_reg <= nnn;
                            end
                            else ev_reg <= EV_ILLEGAL;
                        end
                        4'h3: if (vx == nn) pc_reg <= pc_reg + 12'd2;
                        4'h4: if (vx != nn) pc_reg <= pc_reg + 12'd2;
                        4'h5: if (vx == vy) pc_reg <= pc_reg + 12'd2;
                        4'h9: if (vx != vy) pc_reg <= pc_reg + 12'd2;
                        4'h6: vregs_reg[x] <= nn;
                        4'h7: vregs_reg[x] <= vx + nn;
                        4'h8:
                        begin
                            case (n)
                                4'h0: vregs_reg[x] <= vy;
                                4'h1: vregs_reg[x] <= vx | vy;
                                4'h2: vregs_reg[x] <= vx & vy;
                                4'h3: vregs_reg[x] <= vx ^ vy;
                                4'h4:
                                begin
                                    vregs_reg[x]  <= sum9[7:0];
                                    vregs_reg[15] <= {7'd0, sum9[8]};
                                end
                                4'h5:
                                begin
                                    vregs_reg[x]  <= vx - vy;
                                    vregs_reg[15] <= {7'd0, vx >= vy};
                                end
                                4'h7:
                                begin
                                    vregs_reg[x]  <= vy - vx;
                                    vregs_reg[15] <= {7'd0, vy >= vx};
                                end
                                4'h6:
                                begin
                                    vregs_reg[x]  <= {1'b0, vx[7:1]};
                                    vregs_reg[15] <= {7'd0, vx[0]};
                                end
                                4'hE:
                                begin
                                    vregs_reg[x]  <= {vx[6:0], 1'b0};
                                    vregs_reg[15] <= {7'd0, vx[7]};
                                end
                                default: ev_reg <= EV_ILLEGAL;
                            endcase
                        end
                        4'hA: idx_reg <= nnn;
                        4'hB: pc_reg <= nnn + {4'd0, vregs_reg[0]};
                        4'hC: vregs_reg[x] <= rnd_reg & nn;
                        4'hD:
                        begin
                            ev_reg    <= EV_DRAW;
                            ox_reg    <= vx;
                            oy_reg    <= vy;
                            orows_reg <= n;
                        end
                        4'hE:
                        begin
                            ox_reg <= vx;
                            if (nn == 8'h9E) ev_reg <= EV_KEYDOWN;
                            else if (nn == 8'hA1) ev_reg <= EV_KEYUP;
                            else
                            begin
                                ev_reg <= EV_ILLEGAL;
                                ox_reg <= '0;
                            end
                        end
                        default:
                        begin
                            case (nn)
                                8'h07: vregs_reg[x] <= dt_reg;
                                8'h15: dt_reg <= vx;
                                8'h18: st_reg <= vx;
                                8'h1E: idx_reg <= idx_reg + {4'd0, vx};
                                8'h0A:
                                begin
                                    ev_reg    <= EV_WAIT;
                                    odest_reg <= x;
                                end
                                8'h29:
                                begin
                                    if (vx > 8'd15) ev_reg <= EV_ILLEGAL;
                                    else idx_reg <= 12'(vx * 3'd5);
                                end
                                8'h33:
                                begin
                                    bcd_reg   <= 2'd0;
                                    state_reg <= ST_BCD;
                                end
                                8'h55:
                                begin
                                    cnt_reg   <= '0;
                                    state_reg <= ST_STORE;
                                end
                                8'h65:
                                begin
                                    cnt_reg   <= '0;
                                    state_reg <= ST_LOAD;
                                end
                                default: ev_reg <= EV_ILLEGAL;
                            endcase
                        end
                    endcase
                end
                ST_BCD:
                begin
                    bcd_reg <= bcd_reg + 2'd1;
                    if (bcd_reg == 2'd2) state_reg <= ST_OUT;
                end
                ST_STORE:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg[3:0] == x) state_reg <= ST_OUT;
                end
                ST_LOAD:
                begin
                    state_reg <= ST_LDW;
                end
                ST_LDW:
                begin
                    // return pops from stack read data; otherwise FX65 byte
                    if (cnt_reg == 5'd31)
                    begin
                        pc_reg    <= stk_q;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        vregs_reg[cnt_reg[3:0]] <= ram_q;
                        cnt_reg <= cnt_reg + 5'd1;
                        state_reg <= (cnt_reg[3:0] == x) ? ST_OUT : ST_LOAD;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                    else if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, (st_reg != 8'd0), ord_reg, odest_reg, orows_reg,
                            oy_reg, ox_reg, idx_reg, pc_reg, ev_reg};
endmodule

FILE: hdl/c8ic_checker.sv
// Checker: port-level properties of the CHIP-8 instruction core.
`timescale 1ns / 1ps
module c8ic_checker
    import c8ic_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input ready with result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_not_ready_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("two items at once");
    a_read_event: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[2:0] == KIND_READ |-> ##3
        m_axis_tvalid && m_axis_tdata[2:0] == EV_READ) else $error("read result missing");
endmodule

bind chip8_instruction_core_top c8ic_checker u_c8ic_checker (.*);
